FILE: src/pcko_pkg.sv
// Package with shared types, constants and helper functions for the checksum offload block.
`timescale 1ns / 1ps

package pcko_pkg;

   // Field widths.
   localparam int unsigned WORD_W = 16;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned OFF_W  = 7;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned POS_W  = 17;
   localparam int unsigned HDR_W  = 7;
   localparam int unsigned ADR_W  = 6;

   // Header layout constants.
   localparam logic [3:0]       VERSION_SIX  = 4'd6;
   localparam logic [HDR_W-1:0] V6_HDR_BYTES = 7'd40;
   localparam logic [ADR_W-1:0] V4_ADDR_LO   = 6'd12;
   localparam logic [ADR_W-1:0] V4_ADDR_HI   = 6'd20;
   localparam logic [ADR_W-1:0] V6_ADDR_LO   = 6'd8;
   localparam logic [ADR_W-1:0] V6_ADDR_HI   = 6'd40;

   typedef enum logic [KIND_W-1:0] {
      KIND_IP_HDR,
      KIND_TCP,
      KIND_UDP,
      KIND_ICMP,
      KIND_IGMP,
      KIND_OSPF,
      KIND_VRRP,
      KIND_OTHER
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_ZERO_LEN,
      STAT_UNSUPPORTED,
      STAT_SHORT
   } status_type;

   // One request as held in the input register.
   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic              first_word;
      logic              last_word;
      logic              single_byte;
      kind_type          protocol_kind;
      logic [LEN_W-1:0]  segment_length;
   } pcko_item_type;

   // One result as produced by the accumulator.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] checksum;
      logic [OFF_W-1:0]  checksum_offset;
      status_type        status;
   } pcko_result_type;

   // Offset of the checksum word from the start of the summed region.
   function automatic logic [4:0] cks_word_offset(input kind_type kind);
      logic [4:0] off;
      unique case (kind)
         KIND_IP_HDR: off = 5'd10;
         KIND_TCP:    off = 5'd16;
         KIND_UDP:    off = 5'd6;
         KIND_ICMP:   off = 5'd2;
         KIND_IGMP:   off = 5'd2;
         KIND_OSPF:   off = 5'd12;
         KIND_VRRP:   off = 5'd6;
         KIND_OTHER:  off = 5'd0;
         default:     off = 5'd0;
      endcase
      return off;
   endfunction

   // Protocol number that goes into the pseudo-header.
   function automatic logic [5:0] pseudo_proto(input kind_type kind);
      logic [5:0] num;
      unique case (kind)
         KIND_TCP:  num = 6'd6;
         KIND_UDP:  num = 6'd17;
         KIND_ICMP: num = 6'd58;
         default:   num = 6'd0;
      endcase
      return num;
   endfunction

   // Ones-complement addition with end-around carry.
   function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
   endfunction

endpackage

FILE: src/pcko_ifs.sv
// Request and response channel interfaces for the checksum offload block.
`timescale 1ns / 1ps

interface pcko_req_if;
   import pcko_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic              first_word;
   logic              last_word;
   logic              single_byte;
   logic [KIND_W-1:0] protocol_kind;
   logic [LEN_W-1:0]  segment_length;

   modport source (output valid, data_word, first_word, last_word, single_byte,
                   protocol_kind, segment_length, input ready);
   modport sink (input valid, data_word, first_word, last_word, single_byte,
                 protocol_kind, segment_length, output ready);
endinterface

interface pcko_rsp_if;
   import pcko_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] checksum;
   logic [OFF_W-1:0]  checksum_offset;
   logic [STAT_W-1:0] status;

   modport source (output valid, checksum, checksum_offset, status, input ready);
   modport sink (input valid, checksum, checksum_offset, status, output ready);
endinterface

FILE: src/packet_checksum_offload.sv
// Top level of the packet checksum offload block with its output register.
`timescale 1ns / 1ps

// Packet checksum offload.
// A packet arrives on req_ch as 16-bit network-order words, starting at the
// IP header; the first word carries the protocol kind and the layer-4 length.
// For each packet the block returns one response on rsp_ch on its last word:
// the complemented ones-complement checksum, the byte offset where it belongs
// and a status. Words that arrive outside a packet produce no response.
// Each request passes through an input register, is summed by one short
// single-pass accumulator stage and lands in the output register; a
// response is valid once the last word's result is registered there.
// Throughput is one word per cycle unless rsp_ch stalls; the only loop is the
// 16-bit end-around accumulator, which absorbs a word every cycle it fires.
// Reset is synchronous and clears the packet state and both valid flags.
// While the receiver holds rsp_ch.ready low with a response waiting, the
// input register stops advancing and req_ch.ready drops once it is full;
// no request is lost.
module packet_checksum_offload (
   input  logic        clock,
   input  logic        reset,
   pcko_req_if.sink    req_ch,
   pcko_rsp_if.source  rsp_ch
);
   import pcko_pkg::*;

   logic              out_free;
   logic              advance;
   logic              item_valid;
   pcko_item_type     item;
   pcko_result_type   result;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_checksum_ff;
   logic [OFF_W-1:0]  rsp_offset_ff;
   status_type        rsp_status_ff;

   // The input register moves on whenever the output register can take a result.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = item_valid && out_free;

   pcko_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pcko_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   // Output register.
   always_comb begin
      if (out_free) begin
         rsp_valid_in = result.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result.valid) begin
         rsp_checksum_ff <= result.checksum;
         rsp_offset_ff   <= result.checksum_offset;
         rsp_status_ff   <= result.status;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.checksum        = rsp_checksum_ff;
   assign rsp_ch.checksum_offset = rsp_offset_ff;
   assign rsp_ch.status          = rsp_status_ff;

   // A finished result always reaches the output register on the next edge.
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> rsp_ch.valid)
      else $error("result was not registered for the response channel");

   // A failed packet reports neither checksum nor offset.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STAT_OK)) |->
      ((rsp_ch.checksum == '0) && (rsp_ch.checksum_offset == '0)))
      else $error("non-ok response carries checksum data");

   // A good packet always points at a checksum word past the packet start.
   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STAT_OK)) |-> (rsp_ch.checksum_offset != '0))
      else $error("ok response with zero checksum offset");

   // Results only appear when a request was consumed.
   a_result_needs_item: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (item_valid && item.last_word))
      else $error("result produced without a last word in the input register");

endmodule

FILE: src/pcko_in_stage.sv
// Input register that holds one request until the accumulator consumes it.
`timescale 1ns / 1ps

module pcko_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   pcko_req_if.sink               req_ch,
   input  logic                   advance,
   output logic                   item_valid,
   output pcko_pkg::pcko_item_type item
);
   import pcko_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   pcko_item_type item_ff;
   logic          take;

   // The register is free when empty or when its request moves on this cycle.
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on acceptance and needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_word      <= req_ch.data_word;
         item_ff.first_word     <= req_ch.first_word;
         item_ff.last_word      <= req_ch.last_word;
         item_ff.single_byte    <= req_ch.single_byte;
         item_ff.protocol_kind  <= kind_type'(req_ch.protocol_kind);
         item_ff.segment_length <= req_ch.segment_length;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/pcko_accum.sv
// Per-packet state and the single-pass checksum accumulation for one word.
`timescale 1ns / 1ps

module pcko_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  pcko_pkg::pcko_item_type  item,
   output pcko_pkg::pcko_result_type result
);
   import pcko_pkg::*;

   // Packet state.
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              v6_ff, v6_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   kind_type          kind_ff, kind_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              in_pkt_ff, in_pkt_in;

   logic              active;
   logic              two;
   logic              pseudo;
   logic [WORD_W-1:0] pseudo_w;
   logic [WORD_W-1:0] base_sum;
   logic [HDR_W-1:0]  rs;
   logic [POS_W-1:0]  re;
   logic [HDR_W-1:0]  cpos;
   logic [ADR_W-1:0]  a_lo;
   logic [ADR_W-1:0]  a_hi;
   logic              hit_addr;
   logic              hit_region;
   logic [WORD_W-1:0] addr_w;
   logic [WORD_W-1:0] reg_w;
   logic [WORD_W-1:0] sum_a;
   logic [POS_W:0]    pos_p1;
   logic [POS_W:0]    pos_sum;
   logic [POS_W-1:0]  need;
   status_type        status;

   // A first mark restarts the packet; otherwise the held values apply.
   always_comb begin
      v6_in     = item.first_word ? (item.data_word[15:12] == VERSION_SIX) : v6_ff;
      hdr_in    = item.first_word ?
                  (v6_in ? V6_HDR_BYTES : {1'b0, item.data_word[11:8], 2'b00}) : hdr_ff;
      kind_in   = item.first_word ? item.protocol_kind : kind_ff;
      len_in    = item.first_word ? item.segment_length : len_ff;
      active    = item.first_word || in_pkt_ff;
      in_pkt_in = !item.last_word;
   end

   // Pseudo-header seed and region bounds.
   always_comb begin
      pseudo   = (kind_in == KIND_TCP) || (kind_in == KIND_UDP) ||
                 ((kind_in == KIND_ICMP) && v6_in);
      pseudo_w = {10'd0, pseudo_proto(kind_in)} + len_in;
      if (item.first_word) begin
         base_sum = pseudo ? pseudo_w : '0;
      end else begin
         base_sum = sum_ff;
      end
      rs   = (kind_in == KIND_IP_HDR) ? '0 : hdr_in;
      re   = (kind_in == KIND_IP_HDR) ? {10'd0, hdr_in} : {10'd0, hdr_in} + {1'b0, len_in};
      cpos = rs + {2'b00, cks_word_offset(kind_in)};
      a_lo = v6_in ? V6_ADDR_LO : V4_ADDR_LO;
      a_hi = v6_in ? V6_ADDR_HI : V4_ADDR_HI;
   end

   // Address word and region word, each added with end-around carry.
   always_comb begin
      two        = !(item.last_word && item.single_byte);
      pos_p1     = {1'b0, (item.first_word ? {POS_W{1'b0}} : pos_ff)} + 18'd1;
      hit_addr   = pseudo && (pos_p1 - 18'd1 >= {12'd0, a_lo}) &&
                   (pos_p1 - 18'd1 < {12'd0, a_hi});
      addr_w     = two ? item.data_word : {item.data_word[15:8], 8'h00};
      hit_region = (kind_in != KIND_OTHER) && (pos_p1 - 18'd1 != {11'd0, cpos}) &&
                   (pos_p1 - 18'd1 >= {11'd0, rs});
      reg_w[15:8] = (pos_p1 - 18'd1 < {1'b0, re}) ? item.data_word[15:8] : 8'h00;
      reg_w[7:0]  = (two && (pos_p1 < {1'b0, re})) ? item.data_word[7:0] : 8'h00;
      sum_a      = hit_addr ? ones_add(base_sum, addr_w) : base_sum;
      sum_in     = hit_region ? ones_add(sum_a, reg_w) : sum_a;
   end

   // Byte position saturates at all ones.
   always_comb begin
      pos_sum = pos_p1 + (two ? 18'd1 : 18'd0);
      pos_in  = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
   end

   // Status on the last word, in priority order.
   always_comb begin
      need = (pseudo && ({11'd0, a_hi} > re)) ? {11'd0, a_hi} : re;
      priority if (len_in == '0) begin
         status = STAT_ZERO_LEN;
      end else if (kind_in == KIND_OTHER) begin
         status = STAT_UNSUPPORTED;
      end else if (pos_in < need) begin
         status = STAT_SHORT;
      end else begin
         status = STAT_OK;
      end
      result.valid           = fire && active && item.last_word;
      result.status          = status;
      result.checksum        = (status == STAT_OK) ? ~sum_in : '0;
      result.checksum_offset = (status == STAT_OK) ? cpos : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         pos_ff    <= '0;
         v6_ff     <= 1'b0;
         hdr_ff    <= '0;
         kind_ff   <= KIND_IP_HDR;
         len_ff    <= '0;
         in_pkt_ff <= 1'b0;
      end else if (fire && active) begin
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         v6_ff     <= v6_in;
         hdr_ff    <= hdr_in;
         kind_ff   <= kind_in;
         len_ff    <= len_in;
         in_pkt_ff <= in_pkt_in;
      end
   end

endmodule
